// ----- hdl/smd_pkg.sv -----
// ============================================================================
// smd_pkg
// Types, constants and helper functions shared by the setpoint and meter
// display unit.
// ============================================================================
package smd_pkg;

    // Event codes carried in the command field
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_RAISE  = 2'd1,
        CMD_LOWER  = 2'd2,
        CMD_TOGGLE = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_STEP_SIZE    = 2'd0,
        CFG_MAX_SETPOINT = 2'd1,
        CFG_VOLTAGE_GAIN = 2'd2,
        CFG_CURRENT_GAIN = 2'd3
    } t_cfg_idx;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 8;

    localparam logic [3:0] StepSizeRst    = 4'd2;
    localparam logic [7:0] MaxSetpointRst = 8'd240;
    localparam logic [3:0] VoltageGainRst = 4'd5;
    localparam logic [3:0] CurrentGainRst = 4'd4;

    localparam logic [3:0] LetterVolt = 4'd10;
    localparam logic [3:0] LetterAmp  = 4'd11;
    localparam logic [7:0] SegBlank   = 8'hFF;
    localparam logic [7:0] DpClear    = 8'h7F;

    localparam int SegCount = 12;
    localparam logic [7:0] SegTable [SegCount] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92,
        8'h82, 8'hF8, 8'h80, 8'h90, 8'hC1, 8'h88
    };

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [7:0] dac_code;
        logic       mode;
        logic [7:0] seg_first;
        logic [7:0] seg_second;
        logic [7:0] seg_third;
        logic [7:0] seg_fourth;
    } t_out_item;

    typedef struct packed {
        logic [3:0] step_size;
        logic [7:0] max_setpoint;
        logic [3:0] voltage_gain;
        logic [3:0] current_gain;
    } t_cfg;

    typedef struct packed {
        logic [3:0] thousands;
        logic [3:0] hundreds;
        logic [3:0] tens;
    } t_digits;

    // Active-low segment pattern; codes past the table are blank
    function automatic logic [7:0] seg_pattern(input logic [3:0] code);
        logic [7:0] pat;
        pat = SegBlank;
        if (code < 4'(SegCount)) begin
            pat = SegTable[code];
        end
        return pat;
    endfunction

    // Decimal split of a product (valid up to 3999) by parallel threshold compares
    function automatic t_digits split_digits(input logic [11:0] prod);
        t_digits    d;
        logic [1:0] th;
        logic [3:0] hu;
        logic [3:0] te;
        logic [9:0] rem1;
        logic [6:0] rem2;
        th = '0;
        hu = '0;
        te = '0;
        for (int k = 1; k <= 3; k++) begin
            if (prod >= 12'(k * 1000)) th = 2'(k);
        end
        rem1 = 10'(prod - 12'(th) * 12'd1000);
        for (int k = 1; k <= 9; k++) begin
            if (rem1 >= 10'(k * 100)) hu = 4'(k);
        end
        rem2 = 7'(rem1 - 10'(hu) * 10'd100);
        for (int k = 1; k <= 9; k++) begin
            if (rem2 >= 7'(k * 10)) te = 4'(k);
        end
        d.thousands = {2'b00, th};
        d.hundreds  = hu;
        d.tens      = te;
        return d;
    endfunction

endpackage

// ----- hdl/smd_cfg_regs.sv -----
// ============================================================================
// smd_cfg_regs
// Configuration register file: step size, setpoint limit and the two gains.
// ============================================================================
module smd_cfg_regs
    import smd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [CfgIdxW-1:0]  i_wr_index,
    input  logic [CfgDataW-1:0] i_wr_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_STEP_SIZE:    n_cfg.step_size    = i_wr_data[3:0];
                CFG_MAX_SETPOINT: n_cfg.max_setpoint = i_wr_data[7:0];
                CFG_VOLTAGE_GAIN: n_cfg.voltage_gain = i_wr_data[3:0];
                CFG_CURRENT_GAIN: n_cfg.current_gain = i_wr_data[3:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size    <= StepSizeRst;
            r_cfg.max_setpoint <= MaxSetpointRst;
            r_cfg.voltage_gain <= VoltageGainRst;
            r_cfg.current_gain <= CurrentGainRst;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/smd_panel.sv -----
// ============================================================================
// smd_panel
// Panel state (setpoint, mode, digit codes) and the single-pass update that
// turns one event into the next state and one display result.
// ============================================================================
module smd_panel
    import smd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_update,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [7:0] r_setpoint;
    logic       r_mode;
    logic [3:0] r_digit [4];

    logic [7:0] n_setpoint;
    logic       n_mode;
    logic [3:0] n_digit [4];

    logic [3:0]  gain;
    logic [11:0] product;
    t_digits     digits;
    logic [8:0]  raise_sum;
    logic [7:0]  seg0;
    logic [7:0]  seg1;

    assign gain    = r_mode ? i_cfg.current_gain : i_cfg.voltage_gain;
    assign product = 12'(i_item.sample) * 12'(gain);
    assign digits  = split_digits(product);
    assign raise_sum = 9'(r_setpoint) + 9'(i_cfg.step_size);

    always_comb begin
        n_setpoint = r_setpoint;
        n_mode     = r_mode;
        n_digit    = r_digit;
        unique case (t_cmd'(i_item.command))
            CMD_SAMPLE: begin
                n_digit[0] = digits.thousands;
                n_digit[1] = digits.hundreds;
                n_digit[2] = digits.tens;
                n_digit[3] = r_mode ? LetterAmp : LetterVolt;
            end
            CMD_RAISE: begin
                // clamps even when already above a lowered limit
                n_setpoint = (raise_sum >= 9'(i_cfg.max_setpoint)) ?
                             i_cfg.max_setpoint : raise_sum[7:0];
            end
            CMD_LOWER: begin
                n_setpoint = (r_setpoint <= 8'(i_cfg.step_size)) ?
                             8'd0 : r_setpoint - 8'(i_cfg.step_size);
            end
            CMD_TOGGLE: begin
                n_mode = ~r_mode;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // decimal point follows the mode after this event
    always_comb begin
        seg0 = seg_pattern(n_digit[0]);
        seg1 = seg_pattern(n_digit[1]);
        if (n_mode) begin
            seg0 = seg0 & DpClear;
        end else begin
            seg1 = seg1 & DpClear;
        end
        o_result.dac_code   = n_setpoint;
        o_result.mode       = n_mode;
        o_result.seg_first  = seg0;
        o_result.seg_second = seg1;
        o_result.seg_third  = seg_pattern(n_digit[2]);
        o_result.seg_fourth = seg_pattern(n_digit[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_mode     <= 1'b0;
            r_digit    <= '{default: 4'd0};
        end else if (i_update) begin
            r_setpoint <= n_setpoint;
            r_mode     <= n_mode;
            r_digit    <= n_digit;
        end
    end

endmodule

// ----- hdl/setpoint_and_meter_display_unit.sv -----
// ============================================================================
// setpoint_and_meter_display_unit
// Front-panel setpoint control and four-digit seven-segment meter.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one event
//   per beat: an ADC sample, raise, lower or mode toggle. Output channel
//   (o_out_valid / i_out_stall / o_out_data) returns exactly one beat per
//   event: setpoint, mode and four active-low segment patterns.
//   Configuration writes use i_cfg_valid / o_cfg_ready (always ready) with a
//   register index and data; write only while no event is in flight.
// Timing:
//   An accepted event waits in the input register; the gain multiply, digit
//   split and state update work on it combinationally and the result lands
//   in the output register. o_out_valid rises when that register is written,
//   and the result is taken on an edge where i_out_stall is low. One event
//   is accepted every cycle while the output is not stalled.
// Reset (synchronous, active low): setpoint 0, voltage mode, digits 0,
//   registers at their defaults, both pipeline stages empty.
// Stall: a held result keeps its beat; one more event may wait in the input
//   register, after which o_in_stall rises until the output drains.
// ============================================================================
module setpoint_and_meter_display_unit
    import smd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_item result;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic out_free;
    logic advance;
    logic in_accept;

    assign o_cfg_ready = 1'b1;

    smd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    smd_panel u_panel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (advance),
        .i_item   (r_s1_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_data;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // stall only when both stages hold beats and the receiver blocks
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a full pipe");

    // an accepted event always occupies the input stage next cycle
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted event lost");

    // a waiting event moves into an empty output register
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("result not delivered to output register");

endmodule

// ----- test/setpoint_and_meter_display_unit_tb.sv -----
// ----------------------------------------------------------------------------
// setpoint_and_meter_display_unit_tb
// Self-checking bench for the front-panel setpoint and meter unit. Events go
// in with random gaps, results come out under random output stall, and a
// scoreboard predicts setpoint, mode and segment patterns for every beat.
// Several register settings are used, the extremes among them.
// ----------------------------------------------------------------------------
module setpoint_and_meter_display_unit_tb;
    import smd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QuietLimit   = 2000;
    localparam int SettleCycles = 4;
    localparam int PhaseCount   = 6;
    localparam int PhaseItems   = 155;

    // ------------------------------------------------------------------
    // Panel predictor and expected-beat store
    // ------------------------------------------------------------------
    class panel_scoreboard;
        logic [3:0] step;
        logic [7:0] limit;
        logic [3:0] volt_gain;
        logic [3:0] amp_gain;
        logic [7:0] setpoint;
        logic       mode;
        logic [3:0] digit [4];
        t_out_item  expected_q [$];
        int         errors;
        int         checked;
        int         cfg_writes;
        int         cmd_seen [4];
        int         hit_limit;
        int         hit_zero;

        function new();
            step      = 4'd2;
            limit     = 8'd240;
            volt_gain = 4'd5;
            amp_gain  = 4'd4;
            setpoint  = '0;
            mode      = 1'b0;
            foreach (digit[k]) digit[k] = '0;
            errors     = 0;
            checked    = 0;
            cfg_writes = 0;
            foreach (cmd_seen[k]) cmd_seen[k] = 0;
            hit_limit = 0;
            hit_zero  = 0;
        endfunction

        function logic [7:0] glyph(input logic [3:0] code);
            logic [7:0] pat;
            case (code)
                4'd0:    pat = 8'hC0;
                4'd1:    pat = 8'hF9;
                4'd2:    pat = 8'hA4;
                4'd3:    pat = 8'hB0;
                4'd4:    pat = 8'h99;
                4'd5:    pat = 8'h92;
                4'd6:    pat = 8'h82;
                4'd7:    pat = 8'hF8;
                4'd8:    pat = 8'h80;
                4'd9:    pat = 8'h90;
                4'd10:   pat = 8'hC1;  // U
                4'd11:   pat = 8'h88;  // A
                default: pat = 8'hFF;
            endcase
            return pat;
        endfunction

        function void write_reg(input t_cfg_idx idx, input logic [7:0] data);
            cfg_writes++;
            case (idx)
                CFG_STEP_SIZE:    step      = data[3:0];
                CFG_MAX_SETPOINT: limit     = data;
                CFG_VOLTAGE_GAIN: volt_gain = data[3:0];
                CFG_CURRENT_GAIN: amp_gain  = data[3:0];
                default: ;
            endcase
        endfunction

        function void note_event(input t_in_item it);
            t_cmd        cmd;
            int unsigned product;
            int unsigned sum;
            t_out_item   exp_beat;
            cmd = t_cmd'(it.command);
            cmd_seen[cmd]++;
            case (cmd)
                CMD_SAMPLE: begin
                    product  = int'(it.sample) * int'(mode ? amp_gain : volt_gain);
                    digit[0] = 4'(product / 1000);
                    digit[1] = 4'((product % 1000) / 100);
                    digit[2] = 4'((product % 100) / 10);
                    digit[3] = mode ? LetterAmp : LetterVolt;
                end
                CMD_RAISE: begin
                    sum = int'(setpoint) + int'(step);
                    if (sum >= int'(limit)) begin
                        setpoint = limit;
                        hit_limit++;
                    end else begin
                        setpoint = 8'(sum);
                    end
                end
                CMD_LOWER: begin
                    if (setpoint <= {4'd0, step}) begin
                        setpoint = '0;
                        hit_zero++;
                    end else begin
                        setpoint = setpoint - {4'd0, step};
                    end
                end
                default: mode = ~mode;
            endcase
            exp_beat.dac_code   = setpoint;
            exp_beat.mode       = mode;
            exp_beat.seg_first  = glyph(digit[0]);
            exp_beat.seg_second = glyph(digit[1]);
            // decimal point sits after the first digit for amps, second for volts
            if (mode) exp_beat.seg_first[7] = 1'b0;
            else      exp_beat.seg_second[7] = 1'b0;
            exp_beat.seg_third  = glyph(digit[2]);
            exp_beat.seg_fourth = glyph(digit[3]);
            expected_q.push_back(exp_beat);
        endfunction

        function void compare_field(input string name, input logic [7:0] exp_v,
                                    input logic [7:0] got_v);
            if (got_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
            end
        endfunction

        function void check_result(input t_out_item got);
            t_out_item exp_beat;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
                return;
            end
            exp_beat = expected_q.pop_front();
            checked++;
            compare_field("dac_code",   exp_beat.dac_code,        got.dac_code);
            compare_field("mode",       {7'd0, exp_beat.mode},    {7'd0, got.mode});
            compare_field("seg_first",  exp_beat.seg_first,       got.seg_first);
            compare_field("seg_second", exp_beat.seg_second,      got.seg_second);
            compare_field("seg_third",  exp_beat.seg_third,       got.seg_third);
            compare_field("seg_fourth", exp_beat.seg_fourth,      got.seg_fourth);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    panel_scoreboard sb;
    int              settings_used;

    setpoint_and_meter_display_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_event(input t_cmd cmd, input logic [7:0] smp, input int gap);
        t_in_item it;
        it.command = cmd;
        it.sample  = smp;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_event(it);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    // nibble registers get random junk in the upper bits
    task automatic load_settings(input int stp, input int lim, input int vg, input int cg);
        write_reg(CFG_STEP_SIZE,    {4'($urandom_range(0, 15)), 4'(stp)});
        write_reg(CFG_MAX_SETPOINT, 8'(lim));
        write_reg(CFG_VOLTAGE_GAIN, {4'($urandom_range(0, 15)), 4'(vg)});
        write_reg(CFG_CURRENT_GAIN, {4'($urandom_range(0, 15)), 4'(cg)});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int n_items);
        t_cmd cmd;
        int   sent;
        int   kind;
        int   run_len;
        bit   calm;
        sent = 0;
        while (sent < n_items) begin
            kind    = $urandom_range(0, 9);
            calm    = ($urandom_range(0, 3) == 0);
            run_len = (kind <= 4) ? $urandom_range(1, 30) : $urandom_range(1, 6);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                if (kind <= 2)                cmd = CMD_RAISE;
                else if (kind <= 4)           cmd = CMD_LOWER;
                else if (kind == 5)           cmd = t_cmd'($urandom_range(0, 3));
                else if (kind == 6 && k == 0) cmd = CMD_TOGGLE;
                else                          cmd = CMD_SAMPLE;
                send_event(cmd, pick_sample(), calm ? 0 : pick_gap());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall runs, sometimes long free stretches
    // ------------------------------------------------------------------
    initial begin : out_stall_gen
        int n;
        i_out_stall = 1'b0;
        forever begin
            n = ($urandom_range(0, 99) < 15) ? $urandom_range(50, 150) : $urandom_range(1, 10);
            repeat (n) @(negedge i_clk) i_out_stall <= 1'b0;
            n = pick_gap();
            repeat (n) @(negedge i_clk) i_out_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            sb.check_result(o_out_data);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (i_in_valid && !o_in_stall)
                    || (o_out_valid && !i_out_stall) || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no beat accepted for %0d cycles", $time, QuietLimit);
        $display("setpoint_and_meter_display_unit_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        sb            = new();
        settings_used = 1;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset defaults, digit extremes, decimal point per mode
        send_event(CMD_SAMPLE, 8'd0,   0);
        send_event(CMD_SAMPLE, 8'd255, 0);
        send_event(CMD_TOGGLE, 8'd0,   1);   // digits held, dp moves
        send_event(CMD_SAMPLE, 8'd255, 0);
        send_event(CMD_RAISE,  8'd0,   0);
        send_event(CMD_LOWER,  8'd0,   2);   // equal to step -> zero
        send_event(CMD_LOWER,  8'd0,   0);
        send_event(CMD_TOGGLE, 8'hFF,  0);
        drain_results();

        // full-scale product and clamp at limit
        load_settings(15, 20, 15, 15);
        send_event(CMD_SAMPLE, 8'd255, 0);
        send_event(CMD_RAISE,  8'd0,   0);
        send_event(CMD_RAISE,  8'd0,   0);
        drain_results();

        // limit lowered below setpoint: lower does not clamp, raise does
        load_settings(1, 5, 15, 15);
        send_event(CMD_LOWER,  8'd0,   0);
        send_event(CMD_RAISE,  8'd0,   0);
        drain_results();

        // zero step
        load_settings(0, 3, 0, 15);
        send_event(CMD_LOWER,  8'd0,   0);
        send_event(CMD_RAISE,  8'd0,   0);
        send_event(CMD_LOWER,  8'd0,   0);
        send_event(CMD_SAMPLE, 8'd200, 0);
        send_event(CMD_TOGGLE, 8'd0,   0);
        send_event(CMD_SAMPLE, 8'd128, 0);
        drain_results();

        for (int p = 0; p < PhaseCount; p++) begin
            case (p)
                0:       load_settings(15, 255, 15, 15);
                1:       load_settings(0, 0, 0, 0);
                2:       load_settings(1, 240, 5, 4);
                default: load_settings($urandom_range(0, 15), $urandom_range(0, 255),
                                       $urandom_range(0, 15), $urandom_range(0, 15));
            endcase
            if (p == 3) begin
                // sender holds off until everything is back, then resumes
                run_random(PhaseItems / 2);
                drain_results();
                run_random(PhaseItems / 2);
            end else begin
                run_random(PhaseItems);
            end
            drain_results();
        end

        $display("covered %0d samples, %0d raises, %0d lowers, %0d toggles; %0d beats checked",
                 sb.cmd_seen[CMD_SAMPLE], sb.cmd_seen[CMD_RAISE], sb.cmd_seen[CMD_LOWER],
                 sb.cmd_seen[CMD_TOGGLE], sb.checked);
        $display("%0d register writes over %0d settings; clamped at limit %0d, at zero %0d",
                 sb.cfg_writes, settings_used, sb.hit_limit, sb.hit_zero);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("setpoint_and_meter_display_unit_tb: done, clean");
        end else begin
            $display("setpoint_and_meter_display_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
